/* sv/fpr_pkg.sv */
package fpr_pkg;

  // Table geometry
  localparam int FRAMES     = 8;
  localparam int PAGE_BITS  = 16;

  // Port widths
  localparam int PAGE_W     = 16;
  localparam int CFG_W      = 4;
  localparam int IDX_OUT_W  = 3;
  localparam int COUNT_W    = 32;

  // Derived widths
  localparam int PG_W   = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FILL_W = $clog2(FRAMES + 1);
  localparam int ACT_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef logic [PG_W-1:0]    page_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [FILL_W-1:0]  fill_t;
  typedef logic [ACT_W-1:0]   act_t;
  typedef logic [COUNT_W-1:0] count_t;

  // One registered reference beat
  typedef struct packed {
    logic  valid;
    page_t page;
    logic  wr;
  } req_t;

  // Outcome of the associative search
  typedef struct packed {
    logic  found;
    slot_t slot;
  } look_t;

  // Clamp the frame count register into 1..FRAMES
  function automatic act_t active_frames(logic [CFG_W-1:0] cfg);
    act_t n;
    n = ACT_W'(cfg);
    if (n == '0) begin
      n = ACT_W'(1);
    end
    if (n > ACT_W'(FRAMES)) begin
      n = ACT_W'(FRAMES);
    end
    return n;
  endfunction

  // Saturating increment of a running count
  function automatic count_t sat_inc(count_t v);
    return (&v) ? v : v + COUNT_W'(1);
  endfunction

endpackage

/* sv/fpr_lookup.sv */
module fpr_lookup (
  input  fpr_pkg::page_t page,
  input  fpr_pkg::page_t frame_page [fpr_pkg::FRAMES],
  input  fpr_pkg::act_t  valid_cnt,
  output fpr_pkg::look_t look
);

  // Compare against every valid frame; lowest matching frame wins
  always_comb begin
    look.found = 1'b0;
    look.slot  = '0;
    for (int i = fpr_pkg::FRAMES - 1; i >= 0; i--) begin
      if ((fpr_pkg::ACT_W'(i) < valid_cnt) && (frame_page[i] == page)) begin
        look.found = 1'b1;
        look.slot  = fpr_pkg::SLOT_W'(i);
      end
    end
  end

endmodule

/* sv/fpr_table.sv */
module fpr_table (
  input  logic                           clk,
  input  logic                           rst,
  input  fpr_pkg::req_t                  req,
  input  logic [fpr_pkg::CFG_W-1:0]      frames_cfg,
  output logic                           done,
  output logic                           hit,
  output logic [fpr_pkg::IDX_OUT_W-1:0]  frame_index,
  output fpr_pkg::count_t                replaced_count,
  output fpr_pkg::count_t                write_miss_count
);

  fpr_pkg::page_t  frame_page [fpr_pkg::FRAMES];
  logic [fpr_pkg::FRAMES-1:0] frame_dirty;
  fpr_pkg::fill_t  filled_frames, filled_frames_next;
  fpr_pkg::slot_t  victim_pointer, victim_pointer_next;
  fpr_pkg::count_t replace_counter, replace_counter_next;
  fpr_pkg::count_t write_counter, write_counter_next;

  fpr_pkg::act_t   n_act;
  fpr_pkg::act_t   valid_cnt;
  fpr_pkg::act_t   fill_ext;
  fpr_pkg::act_t   victim_ext;
  fpr_pkg::act_t   slot_inc;
  fpr_pkg::look_t  look;
  fpr_pkg::slot_t  slot;
  logic [31:0]     slot_wide;

  // Frames taking part in lookup
  always_comb begin
    n_act     = fpr_pkg::active_frames(frames_cfg);
    fill_ext  = fpr_pkg::ACT_W'(filled_frames);
    valid_cnt = (fill_ext < n_act) ? fill_ext : n_act;
  end

  fpr_lookup u_lookup (
    .page       (req.page),
    .frame_page (frame_page),
    .valid_cnt  (valid_cnt),
    .look       (look)
  );

  // Pick the fill or victim frame and advance the pointers
  always_comb begin
    filled_frames_next   = filled_frames;
    victim_pointer_next  = victim_pointer;
    replace_counter_next = replace_counter;
    write_counter_next   = write_counter;
    victim_ext           = fpr_pkg::ACT_W'(victim_pointer);
    slot                 = look.slot;
    slot_inc             = '0;
    if (!look.found) begin
      if (fill_ext < n_act) begin
        slot               = fpr_pkg::SLOT_W'(filled_frames);
        filled_frames_next = filled_frames + fpr_pkg::FILL_W'(1);
      end else begin
        slot     = (victim_ext < n_act) ? victim_pointer : '0;
        slot_inc = fpr_pkg::ACT_W'(slot) + fpr_pkg::ACT_W'(1);
        victim_pointer_next = (slot_inc >= n_act) ? '0 : fpr_pkg::SLOT_W'(slot_inc);
      end
      replace_counter_next = fpr_pkg::sat_inc(replace_counter);
      if (req.wr) begin
        write_counter_next = fpr_pkg::sat_inc(write_counter);
      end
    end
    slot_wide = 32'(slot);
  end

  // Frame contents: written on a miss, no reset needed
  always_ff @(posedge clk) begin
    if (req.valid && !look.found) begin
      frame_page[slot] <= req.page;
    end
  end

  // Control state, counts and the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_dirty     <= '0;
      filled_frames   <= '0;
      victim_pointer  <= '0;
      replace_counter <= '0;
      write_counter   <= '0;
      done            <= 1'b0;
    end else begin
      done <= req.valid;
      if (req.valid) begin
        filled_frames   <= filled_frames_next;
        victim_pointer  <= victim_pointer_next;
        replace_counter <= replace_counter_next;
        write_counter   <= write_counter_next;
        if (look.found) begin
          if (req.wr) begin
            frame_dirty[slot] <= 1'b1;
          end
        end else begin
          frame_dirty[slot] <= req.wr;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (req.valid) begin
      hit              <= look.found;
      frame_index      <= look.found ? '0 : slot_wide[fpr_pkg::IDX_OUT_W-1:0];
      replaced_count   <= replace_counter_next;
      write_miss_count <= write_counter_next;
    end
  end

endmodule

/* sv/fifo_page_replacement.sv */
// FIFO page replacement unit. Each page reference (page_number, is_write) taken
// on start returns exactly one result, marked by done: the reference is held
// in the input register, then goes through the associative compare over all
// frames into the result register. busy stays low, so a reference can be
// issued every cycle; the combinational compare across the frame table and the
// pointer update set that rate. The result is shown for one cycle only and
// cannot be stalled: the receiver must capture it when done is high.
// frames_in_use may only be written while no reference is in flight.
module fifo_page_replacement (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [fpr_pkg::PAGE_W-1:0]     page_number,
  input  logic                           is_write,
  input  logic                           cfg_wr_en,
  input  logic [fpr_pkg::CFG_W-1:0]      cfg_wr_data,
  output logic                           done,
  output logic                           hit,
  output logic [fpr_pkg::IDX_OUT_W-1:0]  frame_index,
  output fpr_pkg::count_t                replaced_count,
  output fpr_pkg::count_t                write_miss_count
);

  logic [fpr_pkg::CFG_W-1:0] frames_in_use;
  fpr_pkg::req_t             req;

  // Always ready for the next beat
  assign busy = 1'b0;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= fpr_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      frames_in_use <= cfg_wr_data;
    end
  end

  // Capture the input beat, keeping only the used page bits
  always_ff @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      req.valid <= start && !busy;
    end
    if (start && !busy) begin
      req.page <= page_number[fpr_pkg::PG_W-1:0];
      req.wr   <= is_write;
    end
  end

  fpr_table u_table (
    .clk              (clk),
    .rst              (rst),
    .req              (req),
    .frames_cfg       (frames_in_use),
    .done             (done),
    .hit              (hit),
    .frame_index      (frame_index),
    .replaced_count   (replaced_count),
    .write_miss_count (write_miss_count)
  );

endmodule
